@@ rtl/bcdcal_pkg.sv @@
package bcdcal_pkg;

  typedef enum logic [2:0] {
    FuncMillis  = 3'd0,
    FuncSeconds = 3'd1,
    FuncMinutes = 3'd2,
    FuncHours   = 3'd3,
    FuncDay     = 3'd4,
    FuncMonth   = 3'd5,
    FuncYear    = 3'd6,
    FuncWeekday = 3'd7
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] value;
    logic        bcd;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [9:0] stored;
    logic [4:0] days_in_month;
  } res_t;

  localparam logic [9:0] MillisMax   = 10'd999;
  localparam logic [9:0] MillisBad   = 10'd1000;
  localparam logic [7:0] MinSecMax   = 8'd59;
  localparam logic [5:0] MinSecBad   = 6'd60;
  localparam logic [7:0] HoursMax    = 8'd23;
  localparam logic [4:0] HoursBad    = 5'd24;
  localparam logic [5:0] DayBad      = 6'd32;
  localparam logic [7:0] MonthMax    = 8'd12;
  localparam logic [3:0] MonthBad    = 4'd13;
  localparam logic [7:0] YearMax     = 8'd99;
  localparam logic [6:0] YearBad     = 7'd0;
  localparam logic [7:0] WeekdayMax  = 8'd7;
  localparam logic [3:0] WeekdayBad  = 4'd8;
  localparam logic [3:0] DigitMax    = 4'd9;

  function automatic logic [4:0] month_len(logic [3:0] month, logic [6:0] year);
    logic [4:0] len;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/bcd_calendar_field_validator_core.sv @@
// Calendar register set with per-field write checking.
// Input channel: drive req_i and raise start_i for one cycle; the transaction
// is taken at the rising edge where start_i is high and busy_o is low. busy_o
// stays low, so one transaction can be issued in every cycle.
// req_i.func selects the field, req_i.value carries the value (byte fields use
// bits 7:0), req_i.bcd marks packed BCD for all fields but ms and weekday.
// Result channel: res_o is valid for exactly one cycle while done_o is high,
// once the transaction has passed the input register and then the check/update
// logic into the result register. One result per transaction, in order; the
// throughput is one transaction per cycle.
// The receiver cannot stall: a result not taken in its cycle is lost to it.
// A rejected value stores the field's invalid marker and returns ok low.
// Day writes are checked against the month held when the write is applied,
// which already includes every earlier transaction.
// Reset (rst_ni low, asynchronous) drops any transaction in flight and loads
// ms/sec/min/hour/year/weekday = 0, day = 1, month = 1.
module bcd_calendar_field_validator_core
  import bcdcal_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  logic       valid_q;
  req_t       req_q;
  logic       done_q;
  res_t       res_q, res_d;

  logic [9:0] millis_q, millis_d;
  logic [5:0] seconds_q, seconds_d;
  logic [5:0] minutes_q, minutes_d;
  logic [4:0] hours_q, hours_d;
  logic [5:0] day_q, day_d;
  logic [3:0] month_q, month_d;
  logic [6:0] year_q, year_d;
  logic [3:0] weekday_q, weekday_d;

  logic [7:0] byte_v;
  logic [7:0] bin_v;
  logic       digits_ok;
  logic       ok;
  logic [9:0] stored;
  logic [4:0] cur_len;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
  end

  assign byte_v  = req_q.value[7:0];
  assign cur_len = month_len(month_q, year_q);

  always_comb begin
    digits_ok = 1'b1;
    bin_v     = byte_v;
    if (req_q.bcd) begin
      digits_ok = (byte_v[7:4] <= DigitMax) && (byte_v[3:0] <= DigitMax);
      bin_v     = 8'({4'd0, byte_v[7:4]} * 8'd10 + {4'd0, byte_v[3:0]});
    end
  end

  always_comb begin
    millis_d  = millis_q;
    seconds_d = seconds_q;
    minutes_d = minutes_q;
    hours_d   = hours_q;
    day_d     = day_q;
    month_d   = month_q;
    year_d    = year_q;
    weekday_d = weekday_q;
    ok        = 1'b0;
    stored    = '0;
    case (req_q.func)
      FuncMillis: begin
        ok       = req_q.value <= 16'(MillisMax);
        millis_d = ok ? req_q.value[9:0] : MillisBad;
        stored   = millis_d;
      end
      FuncSeconds: begin
        ok        = digits_ok && (bin_v <= MinSecMax);
        seconds_d = ok ? bin_v[5:0] : MinSecBad;
        stored    = 10'(seconds_d);
      end
      FuncMinutes: begin
        ok        = digits_ok && (bin_v <= MinSecMax);
        minutes_d = ok ? bin_v[5:0] : MinSecBad;
        stored    = 10'(minutes_d);
      end
      FuncHours: begin
        ok      = digits_ok && (bin_v <= HoursMax);
        hours_d = ok ? bin_v[4:0] : HoursBad;
        stored  = 10'(hours_d);
      end
      FuncDay: begin
        ok     = digits_ok && (bin_v != 8'd0) && (bin_v <= 8'(cur_len));
        day_d  = ok ? bin_v[5:0] : DayBad;
        stored = 10'(day_d);
      end
      FuncMonth: begin
        ok      = digits_ok && (bin_v != 8'd0) && (bin_v <= MonthMax);
        month_d = ok ? bin_v[3:0] : MonthBad;
        stored  = 10'(month_d);
      end
      FuncYear: begin
        ok     = digits_ok && (bin_v <= YearMax);
        year_d = ok ? bin_v[6:0] : YearBad;
        stored = 10'(year_d);
      end
      FuncWeekday: begin
        ok        = (byte_v != 8'd0) && (byte_v <= WeekdayMax);
        weekday_d = ok ? byte_v[3:0] : WeekdayBad;
        stored    = 10'(weekday_d);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    res_d.ok            = ok;
    res_d.stored        = stored;
    res_d.days_in_month = month_len(month_d, year_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      millis_q  <= 10'd0;
      seconds_q <= 6'd0;
      minutes_q <= 6'd0;
      hours_q   <= 5'd0;
      day_q     <= 6'd1;
      month_q   <= 4'd1;
      year_q    <= 7'd0;
      weekday_q <= 4'd0;
    end else begin
      done_q <= valid_q;
      if (valid_q) begin
        millis_q  <= millis_d;
        seconds_q <= seconds_d;
        minutes_q <= minutes_d;
        hours_q   <= hours_d;
        day_q     <= day_d;
        month_q   <= month_d;
        year_q    <= year_d;
        weekday_q <= weekday_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o == $past(valid_q))
    else $error("result strobe does not follow the input register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      month_q <= MonthBad && day_q <= DayBad && hours_q <= HoursBad)
    else $error("calendar field beyond its invalid marker");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && res_o.days_in_month != 5'd0) |-> (month_q != 4'd0 && month_q <= 4'd12))
    else $error("month length reported for an invalid month");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (valid_q && req_q.func == FuncDay && ok) |-> (bin_v <= 8'(cur_len)))
    else $error("day accepted beyond the held month length");
`endif

endmodule
